[design/hermite_boundary_curve_evaluator_core_defines.svh]
// ----------------------------------------------------------------------------
// hermite_boundary_curve_evaluator_core_defines
// assertion macros for the hermite curve evaluator
// ----------------------------------------------------------------------------
`ifndef HERMITE_BOUNDARY_CURVE_EVALUATOR_CORE_DEFINES_SVH
`define HERMITE_BOUNDARY_CURVE_EVALUATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HBCE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hbce assertion failed");
`define HBCE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hbce assertion failed");
`else
`define HBCE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HBCE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[design/hbce_pkg.sv]
// ----------------------------------------------------------------------------
// hbce_pkg
// shared types, constants and control structs of the hermite curve evaluator
// ----------------------------------------------------------------------------
package hbce_pkg;

    localparam int SEGMENTS = 64;
    localparam int SEG_W    = 6;
    localparam int WORDS    = 8 * SEGMENTS;
    localparam int WADDR_W  = 9;
    localparam int DATA_W   = 32;
    localparam int T_W      = 17;
    localparam int ACC_W    = 40;
    localparam int CNT_W    = 7;
    localparam int TOL_W    = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [T_W-1:0] T_ONE  = 17'd65536;
    localparam logic [T_W-1:0] U_HALF = 17'd32768;
    localparam logic [3:0]     WSEL_END_PARAM = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_SEG_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOL  = 2'd1;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_EVAL  = 2'd1,
        ACT_FIND  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_T_OUT     = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_ES_RD, S_ES_CHK, S_DIV, S_LD, S_MST, S_MWT,
        S_P0A, S_P0B, S_P0C, S_EPA, S_EPB, S_EPC, S_MPA, S_MPB, S_MCK, S_DONE
    } fsm_state_t;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] a;
        logic [T_W-1:0]          u;
    } mul_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [ACC_W-1:0] p;
    } mul_rsp_t;

    typedef struct packed {
        logic           start;
        logic [T_W-1:0] num;
        logic [T_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [T_W-1:0] q;
    } div_rsp_t;

endpackage

[design/hermite_boundary_curve_evaluator_core.sv]
// ----------------------------------------------------------------------------
// hermite_boundary_curve_evaluator_core
// cubic hermite segment table with evaluate and point search, one shared
// multiplier and divider under a sequencer
// ----------------------------------------------------------------------------
// cycles from the accepting cycle to the result beat: write or idle passes straight to the beat;
//   evaluate searches the segment ends, divides for the local parameter if t lies in a segment, then computes x and y
// find: start point, then each segment end point, then each segment midpoint
// one item at a time, set by the single table read port and the shared multiplier;
//   a result beat not yet taken holds the block until the output register frees
// reset clears control and configuration; the segment table is not cleared
`include "hermite_boundary_curve_evaluator_core_defines.svh"
module hermite_boundary_curve_evaluator_core import hbce_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_action,
    input  logic [SEG_W-1:0]      s_segment,
    input  logic [3:0]            s_word_select,
    input  logic signed [31:0]    s_word_value,
    input  logic [T_W-1:0]        s_param_t,
    input  logic signed [31:0]    s_point_x,
    input  logic signed [31:0]    s_point_y,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_x_out,
    output logic signed [31:0]    m_y_out,
    output logic [T_W-1:0]        m_t_out,
    output logic [SEG_W-1:0]      m_segment_used,
    output logic [1:0]            m_status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]           cfg_data
);

    fsm_state_t state_reg, state_next;
    action_t    mode_reg, mode_next;
    status_t    status_reg, status_next;

    logic [CNT_W-1:0]  seg_in_use_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [SEG_W-1:0]  i_reg, i_next;
    logic [2:0]        rd_cnt_reg, rd_cnt_next;
    logic [1:0]        mstep_reg, mstep_next;
    logic              coord_reg, coord_next;
    logic              m_valid_reg, m_valid_next;

    logic [SEG_W-1:0]  seg_reg, seg_next;
    logic [T_W-1:0]    t_reg, t_next;
    logic [T_W-1:0]    lo_reg, lo_next;
    logic [T_W-1:0]    u_reg, u_next;
    logic [T_W-1:0]    tc_reg, tc_next;
    logic [T_W-1:0]    res_t_reg, res_t_next;
    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic signed [31:0] xr_reg, xr_next, yr_reg, yr_next;
    logic signed [31:0] w_reg [4];
    logic signed [31:0] w_next [4];
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    logic signed [31:0] m_x_reg, m_y_reg;
    logic [T_W-1:0]     m_t_reg;
    logic [SEG_W-1:0]   m_seg_reg;
    logic [1:0]         m_stat_reg;
    logic               m_load;

    logic [CNT_W-1:0]   n_eff;
    logic [SEG_W-1:0]   n_last;
    logic               accept;

    logic [WADDR_W-1:0] words_raddr;
    logic [31:0]        words_rdata;
    logic               words_we, end_we;
    logic [T_W-1:0]     end_wdata, end_rdata;

    logic signed [ACC_W-1:0] p0, p1, t0, t1, c2, c3;
    logic signed [ACC_W-1:0] sum_v;
    logic [T_W:0]            mid_sum;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // |a - b| strictly below the tolerance
    function automatic logic near(input logic signed [31:0] a,
                                  input logic signed [31:0] b,
                                  input logic [TOL_W-1:0]   tol);
        logic signed [32:0] d;
        logic [32:0]        m;
        d = {a[31], a} - {b[31], b};
        m = d[32] ? 33'(-d) : 33'(d);
        return m < {16'd0, tol};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(64'sh7FFFFFFF)) begin
            return 32'sh7FFFFFFF;
        end else if (v < -ACC_W'(64'sh80000000)) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // handshakes
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;

    // effective segment count
    always_comb begin
        if (seg_in_use_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (seg_in_use_reg > CNT_W'(SEGMENTS)) begin
            n_eff = CNT_W'(SEGMENTS);
        end else begin
            n_eff = seg_in_use_reg;
        end
        n_last = SEG_W'(n_eff - CNT_W'(1));
    end

    // table write path
    assign words_we  = accept && (s_action == ACT_WRITE) && !s_word_select[3];
    assign end_we    = accept && (s_action == ACT_WRITE) && (s_word_select == WSEL_END_PARAM);
    assign end_wdata = s_word_value[31] ? '0 :
                       (s_word_value > 32'sd65536) ? T_ONE : s_word_value[T_W-1:0];

    hbce_ram #(.WIDTH(32), .DEPTH(WORDS)) u_words (
        .aclk  (aclk),
        .we    (words_we),
        .waddr ({s_segment, s_word_select[2:0]}),
        .wdata (s_word_value),
        .raddr (words_raddr),
        .rdata (words_rdata)
    );

    hbce_ram #(.WIDTH(T_W), .DEPTH(SEGMENTS)) u_end (
        .aclk  (aclk),
        .we    (end_we),
        .waddr (s_segment),
        .wdata (end_wdata),
        .raddr (i_reg),
        .rdata (end_rdata)
    );

    hbce_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mul_req), .rsp(mul_rsp));
    hbce_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    // hermite coefficients from the loaded words
    always_comb begin
        p0 = ACC_W'(w_reg[0]);
        p1 = ACC_W'(w_reg[1]);
        t0 = ACC_W'(w_reg[2]);
        t1 = ACC_W'(w_reg[3]);
        c3 = (p0 <<< 1) - (p1 <<< 1) + t0 + t1;
        c2 = (p1 <<< 1) + p1 - (p0 <<< 1) - p0 - (t0 <<< 1) - t1;
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        status_next  = status_reg;
        i_next       = i_reg;
        rd_cnt_next  = rd_cnt_reg;
        mstep_next   = mstep_reg;
        coord_next   = coord_reg;
        seg_next     = seg_reg;
        t_next       = t_reg;
        lo_next      = lo_reg;
        u_next       = u_reg;
        tc_next      = tc_reg;
        res_t_next   = res_t_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        xr_next      = xr_reg;
        yr_next      = yr_reg;
        acc_next     = acc_reg;
        w_next       = w_reg;
        m_load       = 1'b0;
        words_raddr  = {seg_reg, rd_cnt_reg[1:0], coord_reg};
        mul_req.start = 1'b0;
        mul_req.a    = (mstep_reg == 2'd0) ? c3 : acc_reg;
        mul_req.u    = u_reg;
        div_req.start = 1'b0;
        div_req.num  = t_reg - lo_reg;
        div_req.den  = end_rdata - lo_reg;
        sum_v        = '0;
        mid_sum      = {1'b0, lo_reg} + {1'b0, tc_reg};

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    mode_next   = action_t'(s_action);
                    status_next = STAT_OK;
                    res_t_next  = '0;
                    seg_next    = '0;
                    unique case (action_t'(s_action))
                        ACT_WRITE: begin
                            seg_next   = s_segment;
                            state_next = S_DONE;
                        end
                        ACT_EVAL: begin
                            t_next     = s_param_t;
                            i_next     = '0;
                            lo_next    = '0;
                            state_next = S_ES_RD;
                        end
                        ACT_FIND: begin
                            px_next    = s_point_x;
                            py_next    = s_point_y;
                            state_next = S_P0A;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            // knot interval search
            S_ES_RD: state_next = S_ES_CHK;
            S_ES_CHK: begin
                rd_cnt_next = '0;
                coord_next  = 1'b0;
                if (t_reg >= lo_reg && t_reg <= end_rdata) begin
                    seg_next = i_reg;
                    if (end_rdata == lo_reg) begin
                        u_next     = '0;
                        state_next = S_LD;
                    end else begin
                        div_req.start = 1'b1;
                        state_next    = S_DIV;
                    end
                end else if (i_reg == n_last) begin
                    seg_next    = n_last;
                    u_next      = t_reg;
                    status_next = STAT_T_OUT;
                    state_next  = S_LD;
                end else begin
                    lo_next    = end_rdata;
                    i_next     = i_reg + 1'b1;
                    state_next = S_ES_RD;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    u_next     = div_rsp.q;
                    state_next = S_LD;
                end
            end
            // load p0, p1, t0, t1 of one coordinate
            S_LD: begin
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (rd_cnt_reg != 3'd0) begin
                    w_next[rd_cnt_reg[1:0] - 2'd1] = words_rdata;
                end
                if (rd_cnt_reg == 3'd4) begin
                    rd_cnt_next = '0;
                    mstep_next  = '0;
                    state_next  = S_MST;
                end
            end
            // horner steps through the shared multiplier
            S_MST: begin
                mul_req.start = 1'b1;
                state_next    = S_MWT;
            end
            S_MWT: begin
                if (mul_rsp.done) begin
                    case (mstep_reg)
                        2'd0: begin
                            acc_next   = c2 + mul_rsp.p;
                            mstep_next = 2'd1;
                            state_next = S_MST;
                        end
                        2'd1: begin
                            acc_next   = t0 + mul_rsp.p;
                            mstep_next = 2'd2;
                            state_next = S_MST;
                        end
                        default: begin
                            sum_v = p0 + mul_rsp.p;
                            if (!coord_reg) begin
                                xr_next    = sat32(sum_v);
                                coord_next = 1'b1;
                                state_next = S_LD;
                            end else begin
                                yr_next    = sat32(sum_v);
                                state_next = (mode_reg == ACT_EVAL) ? S_DONE : S_MCK;
                            end
                        end
                    endcase
                end
            end
            // start point of segment 0
            S_P0A: begin
                words_raddr = WADDR_W'(0);
                state_next  = S_P0B;
            end
            S_P0B: begin
                words_raddr = WADDR_W'(1);
                xr_next     = words_rdata;
                state_next  = S_P0C;
            end
            S_P0C: begin
                if (near(xr_reg, px_reg, tol_reg) && near(words_rdata, py_reg, tol_reg)) begin
                    state_next = S_DONE;
                end else begin
                    i_next     = '0;
                    state_next = S_EPA;
                end
            end
            // segment end points
            S_EPA: begin
                words_raddr = {i_reg, 3'd2};
                state_next  = S_EPB;
            end
            S_EPB: begin
                words_raddr = {i_reg, 3'd3};
                xr_next     = words_rdata;
                tc_next     = end_rdata;
                state_next  = S_EPC;
            end
            S_EPC: begin
                if (near(xr_reg, px_reg, tol_reg) && near(words_rdata, py_reg, tol_reg)) begin
                    res_t_next = tc_reg;
                    seg_next   = i_reg;
                    state_next = S_DONE;
                end else if (i_reg == n_last) begin
                    i_next     = '0;
                    lo_next    = '0;
                    state_next = S_MPA;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_EPA;
                end
            end
            // segment midpoints
            S_MPA: state_next = S_MPB;
            S_MPB: begin
                tc_next     = end_rdata;
                seg_next    = i_reg;
                coord_next  = 1'b0;
                u_next      = U_HALF;
                rd_cnt_next = '0;
                state_next  = S_LD;
            end
            S_MCK: begin
                if (near(xr_reg, px_reg, tol_reg) && near(yr_reg, py_reg, tol_reg)) begin
                    res_t_next = mid_sum[T_W:1];
                    state_next = S_DONE;
                end else if (i_reg == n_last) begin
                    seg_next    = '0;
                    status_next = STAT_NOT_FOUND;
                    state_next  = S_DONE;
                end else begin
                    lo_next    = tc_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = S_MPA;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_load     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // output beat register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (m_load) begin
            m_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            mode_reg       <= ACT_NONE;
            i_reg          <= '0;
            rd_cnt_reg     <= '0;
            mstep_reg      <= '0;
            coord_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
            seg_in_use_reg <= CNT_W'(1);
            tol_reg        <= TOL_W'(1);
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            i_reg       <= i_next;
            rd_cnt_reg  <= rd_cnt_next;
            mstep_reg   <= mstep_next;
            coord_reg   <= coord_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_SEG_IN_USE: seg_in_use_reg <= cfg_data[CNT_W-1:0];
                    CFG_MATCH_TOL:  tol_reg        <= cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        seg_reg    <= seg_next;
        t_reg      <= t_next;
        lo_reg     <= lo_next;
        u_reg      <= u_next;
        tc_reg     <= tc_next;
        res_t_reg  <= res_t_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        xr_reg     <= xr_next;
        yr_reg     <= yr_next;
        acc_reg    <= acc_next;
        w_reg      <= w_next;
        if (m_load) begin
            m_x_reg    <= (mode_reg == ACT_EVAL) ? xr_reg : '0;
            m_y_reg    <= (mode_reg == ACT_EVAL) ? yr_reg : '0;
            m_t_reg    <= res_t_reg;
            m_seg_reg  <= seg_reg;
            m_stat_reg <= status_reg;
        end
    end

    assign m_x_out        = m_x_reg;
    assign m_y_out        = m_y_reg;
    assign m_t_out        = m_t_reg;
    assign m_segment_used = m_seg_reg;
    assign m_status       = m_stat_reg;

    // checks
    `HBCE_ASSERT_NXT(a_eval_starts_search, aclk, aresetn, accept && s_action == ACT_EVAL, state_reg == S_ES_RD)
    `HBCE_ASSERT_IMP(a_div_done_in_div, aclk, aresetn, div_rsp.done, state_reg == S_DIV)
    `HBCE_ASSERT_IMP(a_mul_done_in_wait, aclk, aresetn, mul_rsp.done, state_reg == S_MWT)
    `HBCE_ASSERT_IMP(a_beat_from_done, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == S_DONE)

endmodule

[design/hbce_ram.sv]
// ----------------------------------------------------------------------------
// hbce_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module hbce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/hbce_div.sv]
// ----------------------------------------------------------------------------
// hbce_div
// restoring divider: quotient of (num << 16) / den, one bit per cycle
// ----------------------------------------------------------------------------
module hbce_div import hbce_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int DVD_W = T_W + 16;
    localparam int STEP_W = $clog2(DVD_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [DVD_W-1:0]    sh_reg, sh_next;
    logic [T_W-1:0]      rem_reg, rem_next;
    logic [T_W-1:0]      den_reg, den_next;
    logic [T_W:0]        rem_sh;
    logic                qbit;

    // one quotient bit per step
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        rem_sh    = {rem_reg, sh_reg[DVD_W-1]};
        qbit      = (rem_sh >= {1'b0, den_reg});
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sh_next   = {req.num, 16'd0};
            rem_next  = '0;
            den_next  = req.den;
        end else if (busy_reg) begin
            rem_next = qbit ? T_W'(rem_sh - {1'b0, den_reg}) : rem_sh[T_W-1:0];
            sh_next  = {sh_reg[DVD_W-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.q    = sh_reg[T_W-1:0];

endmodule

[design/hbce_mul.sv]
// ----------------------------------------------------------------------------
// hbce_mul
// shared q16 multiplier: round(a * u / 2^16), low then high partial product through one multiplier on separate cycles
// ----------------------------------------------------------------------------
module hbce_mul import hbce_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    localparam int HALF_W = ACC_W / 2;
    localparam int PROD_W = HALF_W + 1 + T_W + 1;
    localparam int TOT_W  = ACC_W + T_W + 3;

    logic                     busy_reg, phase_reg, done_reg;
    logic signed [ACC_W-1:0]  a_reg;
    logic [T_W-1:0]           u_reg;
    logic signed [PROD_W-1:0] lo_reg;
    logic signed [ACC_W-1:0]  p_reg;
    logic signed [HALF_W:0]   opnd;
    logic signed [T_W:0]      uop;
    logic signed [PROD_W-1:0] prod;
    logic signed [TOT_W-1:0]  total;
    logic signed [TOT_W-1:0]  rounded;

    // low half unsigned, high half signed, through one multiplier
    always_comb begin
        opnd    = phase_reg ? {a_reg[ACC_W-1], a_reg[ACC_W-1:HALF_W]}
                            : {1'b0, a_reg[HALF_W-1:0]};
        uop     = {1'b0, u_reg};
        prod    = PROD_W'(opnd * uop);
        total   = (TOT_W'(prod) <<< HALF_W) + TOT_W'(lo_reg);
        rounded = (total + TOT_W'(32768)) >>> 16;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
            end else if (busy_reg) begin
                phase_reg <= ~phase_reg;
                if (phase_reg) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg <= req.a;
            u_reg <= req.u;
        end
        if (busy_reg && !phase_reg) begin
            lo_reg <= prod;
        end
        if (busy_reg && phase_reg) begin
            p_reg <= rounded[ACC_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.p    = p_reg;

endmodule
